### src/running_median_tracker_macros.svh
// Assertion macros for the running median tracker RTL.
`ifndef RUNNING_MEDIAN_TRACKER_MACROS_SVH
`define RUNNING_MEDIAN_TRACKER_MACROS_SVH

// Checked property, masked while reset is high.
`define RMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define RMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/rmt_pkg.sv
// Types and constants for the running median tracker.
package rmt_pkg;

  localparam int CAPACITY   = 256;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int SLOT_NUM   = NUM_GROUPS * GROUP_SIZE;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start_new;
  } req_t;

  typedef struct packed {
    logic signed [16:0] median_times_two;
    logic [CNT_W-1:0]   sample_count;
    logic               dropped;
  } rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    sample_t          sample;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
  } cell_ctrl_t;

endpackage

### src/running_median_tracker.sv
// Running median tracker: sorted insertion chain of CAPACITY cells.
// Stages: insert, group merge, final merge; the result then sits in the output register.
// A new item is not taken until the previous one has
// left the merge stages, while a finished result may still sit in the output register.
// Reset (rst, synchronous): empties the store, clears all valid flags; cell contents undefined.
module running_median_tracker import rmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

`include "running_median_tracker_macros.svh"

  // Number of kept samples.
  logic [CNT_W-1:0] count;
  // Stage flags: s1 = chain updated, s2 = group merge registered.
  logic             s1_valid;
  logic             s2_valid;
  logic             drop_flag;

  logic             req_xfer;
  logic             s2_move;
  logic [CNT_W-1:0] eff_count;
  logic             full;
  logic [CNT_W-1:0] lo_wide;
  logic [CNT_W-1:0] hi_wide;
  cell_ctrl_t       ctrl;

  // No transfer is taken while reset is high.
  assign req_ready = !rst && !s1_valid && !s2_valid;
  assign req_xfer  = req_valid && req_ready;
  assign s2_move   = s2_valid && (!rsp_valid || rsp_ready);

  // A start flag empties the store before this sample is placed.
  assign eff_count = req.start_new ? '0 : count;
  assign full      = (eff_count == CNT_W'(CAPACITY));

  // Middle positions of the kept samples; equal when the count is odd.
  assign lo_wide = (count - CNT_W'(1)) >> 1;
  assign hi_wide = count >> 1;

  always_comb begin
    ctrl.ins    = req_xfer && !full;
    ctrl.sample = req.sample;
    ctrl.count  = eff_count;
    ctrl.lo_idx = lo_wide[IDX_W-1:0];
    ctrl.hi_idx = hi_wide[IDX_W-1:0];
  end

  // ---- insertion chain ----
  logic    keep  [CAPACITY];
  sample_t value [CAPACITY];
  sample_t lo_slot [SLOT_NUM];
  sample_t hi_slot [SLOT_NUM];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic    p_keep;
    sample_t p_value;
    if (i == 0) begin : g_head
      // Nothing sits ahead of the first slot.
      assign p_keep  = 1'b1;
      assign p_value = '0;
    end else begin : g_link
      assign p_keep  = keep[i-1];
      assign p_value = value[i-1];
    end
    rmt_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .prev_keep  (p_keep),
      .prev_value (p_value),
      .keep       (keep[i]),
      .value      (value[i]),
      .lo_part    (lo_slot[i]),
      .hi_part    (hi_slot[i])
    );
  end

  // Unused slots of the last group merge as zero.
  for (genvar i = CAPACITY; i < SLOT_NUM; i++) begin : g_pad
    assign lo_slot[i] = '0;
    assign hi_slot[i] = '0;
  end

  // ---- group merge (first stage of the OR tree) ----
  sample_t grp_lo [NUM_GROUPS];
  sample_t grp_hi [NUM_GROUPS];

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    sample_t lo_in [GROUP_SIZE];
    sample_t hi_in [GROUP_SIZE];
    for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_tap
      assign lo_in[k] = lo_slot[g*GROUP_SIZE + k];
      assign hi_in[k] = hi_slot[g*GROUP_SIZE + k];
    end
    rmt_group_or u_group (
      .clk    (clk),
      .en     (s1_valid),
      .lo_in  (lo_in),
      .hi_in  (hi_in),
      .lo_out (grp_lo[g]),
      .hi_out (grp_hi[g])
    );
  end

  // ---- final merge and sum ----
  sample_t            mid_lo;
  sample_t            mid_hi;
  logic signed [16:0] mid_sum;

  always_comb begin
    mid_lo = '0;
    mid_hi = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      mid_lo = mid_lo | grp_lo[g];
      mid_hi = mid_hi | grp_hi[g];
    end
    mid_sum = {mid_lo[15], mid_lo} + {mid_hi[15], mid_hi};
  end

  // ---- control and output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_xfer) begin
        count     <= full ? eff_count : eff_count + CNT_W'(1);
        drop_flag <= full;
      end
      s1_valid <= req_xfer;
      if (s1_valid) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        rsp_valid            <= 1'b1;
        rsp.median_times_two <= mid_sum;
        rsp.sample_count     <= count;
        rsp.dropped          <= drop_flag;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---- checks ----
  `RMT_ASSERT_ALWAYS(a_reset_idle, rst |=> !rsp_valid && !s1_valid && !s2_valid, "flags set after reset")
  `RMT_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "kept count above capacity")
  `RMT_ASSERT(a_one_in_flight, !(s1_valid && s2_valid), "two items in the merge stages")
  `RMT_ASSERT(a_drop_full, rsp_valid && rsp.dropped |-> rsp.sample_count == CNT_W'(CAPACITY), "drop reported with room left")
  `RMT_ASSERT(a_odd_even, rsp_valid && rsp.sample_count[0] |-> !rsp.median_times_two[0], "odd count gave odd doubled median")
  `RMT_ASSERT(a_count_step, req_xfer && !full |=> count == $past(eff_count) + CNT_W'(1), "kept count did not advance on insert")

endmodule

### src/rmt_cell.sv
// One slot of the sorted insertion chain.
module rmt_cell import rmt_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic             prev_keep,
  input  sample_t          prev_value,
  output logic             keep,
  output sample_t          value,
  output sample_t          lo_part,
  output sample_t          hi_part
);

  // Occupied and not above the new sample: stays put.
  assign keep    = (CNT_W'(idx) < ctrl.count) && (value <= ctrl.sample);
  assign lo_part = (idx == ctrl.lo_idx) ? value : '0;
  assign hi_part = (idx == ctrl.hi_idx) ? value : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins && !keep) begin
      value <= prev_keep ? ctrl.sample : prev_value;
    end
  end

endmodule

### src/rmt_group_or.sv
// Registered OR-merge of one group of one-hot masked middle values.
module rmt_group_or import rmt_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  sample_t lo_in [GROUP_SIZE],
  input  sample_t hi_in [GROUP_SIZE],
  output sample_t lo_out,
  output sample_t hi_out
);

  sample_t lo_next;
  sample_t hi_next;

  always_comb begin
    lo_next = '0;
    hi_next = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      lo_next = lo_next | lo_in[k];
      hi_next = hi_next | hi_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_out <= lo_next;
      hi_out <= hi_next;
    end
  end

endmodule

### dv/running_median_check.sv
// Watches both channels of the running median tracker, predicts each median and checks it.
module running_median_check
  import rmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOWN = 10;

  sample_t kept [CAPACITY];
  int      kept_n = 0;
  rsp_t    medians_due [$];
  int      fails = 0;
  int      owed = 0;

  assign fail_count   = fails;
  assign results_owed = owed;

  // Insert into the ascending store, after any equal values; full store drops the sample.
  task automatic admit_sample(input req_t r, output rsp_t m);
    int pos;
    int lo;
    int hi;
    m.dropped = 1'b0;
    if (r.start_new) kept_n = 0;
    if (kept_n < CAPACITY) begin
      pos = 0;
      while (pos < kept_n && kept[pos] <= r.sample) pos++;
      for (int i = kept_n; i > pos; i--) kept[i] = kept[i-1];
      kept[pos] = r.sample;
      kept_n++;
    end else begin
      m.dropped = 1'b1;
    end
    // at least one sample is kept here; odd count picks the same entry twice
    lo = kept[(kept_n - 1) / 2];
    hi = kept[kept_n / 2];
    m.median_times_two = 17'(lo + hi);
    m.sample_count     = CNT_W'(kept_n);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      kept_n = 0;
      medians_due.delete();
    end else begin
      if (req_valid && req_ready) begin
        admit_sample(req, want);
        medians_due.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        if (medians_due.size() == 0) begin
          fails++;
          if (fails <= SHOWN)
            $display("%0t: unexpected result median2=%0d count=%0d dropped=%0b",
                     $time, rsp.median_times_two, rsp.sample_count, rsp.dropped);
        end else begin
          want = medians_due.pop_front();
          if (rsp.median_times_two !== want.median_times_two ||
              rsp.sample_count !== want.sample_count || rsp.dropped !== want.dropped) begin
            fails++;
            if (fails <= SHOWN)
              $display("%0t: mismatch median2 %0d/%0d count %0d/%0d dropped %0b/%0b (exp/act)",
                       $time, want.median_times_two, rsp.median_times_two,
                       want.sample_count, rsp.sample_count, want.dropped, rsp.dropped);
          end
        end
      end
    end
    owed = medians_due.size();
  end

endmodule

### dv/running_median_tracker_test.sv
// Top of the running median tracker testbench: clock, reset, stimulus, stalls and verdict.
module running_median_tracker_test;
  import rmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Settling time for the block after the last result has come back.
  localparam int SETTLE = 8;
  localparam int PHASE_ITEMS = 250;

  localparam sample_t S_MAX  = 16'sh7FFF;
  localparam sample_t S_MIN  = 16'sh8000;
  localparam sample_t S_ZERO = 16'sh0000;
  localparam sample_t S_NEG1 = 16'shFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int results_owed;

  // Idle and stall odds in percent, changed per phase.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int quiet = 0;

  always #10 clk = ~clk;

  running_median_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  running_median_check u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // Receiver: ready drawn fresh every cycle against the current stall odds.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Mostly full-range values; some from a narrow band so equal samples pile up,
  // and some pinned to the extremes.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1: return sample_t'(int'($urandom_range(0, 6)) - 3);
      2: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return S_ZERO;
          default: return S_NEG1;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // One transfer on the request side. Valid holds high with a steady payload
  // until req_ready is seen at an edge; the random gap only comes before raising it.
  task automatic send_sample(input sample_t s, input logic st);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{sample: s, start_new: st};
    do @(posedge clk); while (!req_ready);
  endtask

  // Hold off the sender until every predicted median has come back, then let
  // the pipeline settle. The first edge makes sure the checker has counted
  // the last request.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sent;
    int run;
    int tx_pct [4] = '{0, 66, 0, 28};
    int rx_pct [4] = '{0, 0, 66, 28};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: first sample after reset without a start flag, both extremes
    // alone and together, sign crossings, and runs of equal samples.
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_ZERO, 1'b1);
    send_sample(S_NEG1, 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(7), 1'b1);
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(-7), 1'b0);
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(-7), 1'b0);
    send_sample(sample_t'(-7), 1'b0);
    send_sample(S_NEG1, 1'b1);
    send_sample(S_NEG1, 1'b0);
    drain();

    // Random streams in four idling phases. Most streams are short; now and
    // then one, and always the first, is drawn past capacity; but a phase stops
    // at PHASE_ITEMS samples, below capacity, so no sample is ever dropped.
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 0 && sent == 0)
          run = CAPACITY + 6;
        else if ($urandom_range(0, 11) == 0)
          run = $urandom_range(CAPACITY, CAPACITY + 14);
        else
          run = $urandom_range(1, 40);
        for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
          // stray restarts inside a stream now and then
          send_sample(pick_sample(), (k == 0) || ($urandom_range(0, 49) == 0));
          sent++;
          if (ph == 1 && sent == PHASE_ITEMS / 2) drain();
        end
      end
      drain();
    end

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
